[rtl/minv3_pkg.sv]
package minv3_pkg;

	// field width of the Q-format elements, fixed by the port structs
	localparam int DATA_W = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int MQ_DEPTH_DEF = 4;
	localparam int OQ_DEPTH_DEF = 2;

	// exact widths: products, cofactors, determinant
	localparam int PROD_W = 2 * DATA_W;
	localparam int COF_W = 2 * DATA_W + 1;
	localparam int DET_W = 3 * DATA_W + 3;

	// cofactor k = a[p] * a[q] - a[u] * a[v], elements numbered row by row
	localparam logic [3:0] COF_IDX [9][4] = '{
		'{4'd4, 4'd8, 4'd5, 4'd7},
		'{4'd2, 4'd7, 4'd1, 4'd8},
		'{4'd1, 4'd5, 4'd2, 4'd4},
		'{4'd5, 4'd6, 4'd3, 4'd8},
		'{4'd0, 4'd8, 4'd2, 4'd6},
		'{4'd2, 4'd3, 4'd0, 4'd5},
		'{4'd3, 4'd7, 4'd4, 4'd6},
		'{4'd1, 4'd6, 4'd0, 4'd7},
		'{4'd0, 4'd4, 4'd1, 4'd3}
	};

	// determinant = a0 * cof0 + a1 * cof3 + a2 * cof6
	localparam logic [3:0] DET_COF [3] = '{4'd0, 4'd3, 4'd6};

	typedef struct packed {
		logic signed [DATA_W-1:0] a00;
		logic signed [DATA_W-1:0] a01;
		logic signed [DATA_W-1:0] a02;
		logic signed [DATA_W-1:0] a10;
		logic signed [DATA_W-1:0] a11;
		logic signed [DATA_W-1:0] a12;
		logic signed [DATA_W-1:0] a20;
		logic signed [DATA_W-1:0] a21;
		logic signed [DATA_W-1:0] a22;
	} mat_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] inv00;
		logic signed [DATA_W-1:0] inv01;
		logic signed [DATA_W-1:0] inv02;
		logic signed [DATA_W-1:0] inv10;
		logic signed [DATA_W-1:0] inv11;
		logic signed [DATA_W-1:0] inv12;
		logic signed [DATA_W-1:0] inv20;
		logic signed [DATA_W-1:0] inv21;
		logic signed [DATA_W-1:0] inv22;
		logic                     singular;
	} inv_t;

	// beat handed from the front to the back through the middle queue
	typedef struct packed {
		logic [8:0][COF_W-1:0] cof;
		logic [DET_W-1:0]      det;
		logic                  sing;
	} item_t;

endpackage

[rtl/minv3_fifo.sv]
module minv3_fifo #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [CNTW-1:0]  cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full = (cnt_q == CNTW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_q];

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// store the incoming beat
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

[rtl/minv3_front.sv]
module minv3_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  minv3_pkg::mat_t   mat,
	output logic              mq_push,
	input  logic              mq_full,
	output minv3_pkg::item_t  mq_item
);

	import minv3_pkg::*;

	logic signed [DATA_W-1:0] a_c [9];

	logic                     v_s1, v_s2, v_s3, v_s4, v_s5;
	logic                     en;
	logic signed [PROD_W-1:0] prod_s1 [18];
	logic signed [DATA_W-1:0] a_s1 [3];
	logic signed [COF_W-1:0]  cof_s2 [9];
	logic signed [DATA_W-1:0] a_s2 [3];
	logic signed [COF_W-1:0]  cof_s3 [9];
	logic signed [COF_W-1:0]  plo_s3 [3];
	logic signed [COF_W-1:0]  phi_s3 [3];
	logic signed [COF_W-1:0]  cof_s4 [9];
	logic signed [DET_W-1:0]  term_s4 [3];
	logic signed [COF_W-1:0]  cof_s5 [9];
	logic signed [DET_W-1:0]  det_s5;

	assign a_c[0] = mat.a00;
	assign a_c[1] = mat.a01;
	assign a_c[2] = mat.a02;
	assign a_c[3] = mat.a10;
	assign a_c[4] = mat.a11;
	assign a_c[5] = mat.a12;
	assign a_c[6] = mat.a20;
	assign a_c[7] = mat.a21;
	assign a_c[8] = mat.a22;

	// hold the whole pipe while its last beat cannot enter the queue
	assign full = v_s5 && mq_full;
	assign en = !full;
	assign mq_push = v_s5 && !mq_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// form the eighteen products
			for (int k = 0; k < 9; k++) begin
				prod_s1[2*k]   <= a_c[COF_IDX[k][0]] * a_c[COF_IDX[k][1]];
				prod_s1[2*k+1] <= a_c[COF_IDX[k][2]] * a_c[COF_IDX[k][3]];
			end
			for (int j = 0; j < 3; j++) begin
				a_s1[j] <= a_c[j];
			end
			// take the cofactor differences
			for (int k = 0; k < 9; k++) begin
				cof_s2[k] <= COF_W'(prod_s1[2*k]) - COF_W'(prod_s1[2*k+1]);
			end
			a_s2 <= a_s1;
			// split each first-row cofactor into a low and a high half
			for (int j = 0; j < 3; j++) begin
				plo_s3[j] <= a_s2[j] *
					$signed({1'b0, cof_s2[DET_COF[j]][DATA_W-1:0]});
				phi_s3[j] <= a_s2[j] * $signed(cof_s2[DET_COF[j]][COF_W-1:DATA_W]);
			end
			cof_s3 <= cof_s2;
			// recombine the halves
			for (int j = 0; j < 3; j++) begin
				term_s4[j] <= (DET_W'(phi_s3[j]) <<< DATA_W) + DET_W'(plo_s3[j]);
			end
			cof_s4 <= cof_s3;
			// sum the expansion
			det_s5 <= term_s4[0] + term_s4[1] + term_s4[2];
			cof_s5 <= cof_s4;
		end
	end

	// classify on the way out
	always_comb begin
		for (int k = 0; k < 9; k++) begin
			mq_item.cof[k] = cof_s5[k];
		end
		mq_item.det = det_s5;
		mq_item.sing = (det_s5 == '0);
	end

endmodule

[rtl/minv3_back.sv]
module minv3_back #(
	parameter int FRAC_BITS = minv3_pkg::FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              mq_empty,
	input  minv3_pkg::item_t  mq_item,
	output logic              mq_pop,
	input  logic              oq_full,
	output logic              oq_push,
	output minv3_pkg::inv_t   oq_data
);

	import minv3_pkg::*;

	// remainder wide enough for the divisor shifted by a full quotient
	localparam int XW = 4 * DATA_W + 3;
	// load stage, overflow check, one stage per quotient bit
	localparam int NS = DATA_W + 2;

	logic                     en;
	logic                     v_s [NS];
	logic [XW-1:0]            rem_s [NS][9];
	logic [DATA_W-1:0]        quo_s [1:NS-1][9];
	logic                     big_s [1:NS-1][9];
	logic                     neg_s [NS][9];
	logic [XW-1:0]            dmag_s [NS];
	logic                     sing_s [NS];

	logic signed [DET_W-1:0]  det_c;
	logic                     dneg_c;
	logic [DET_W-1:0]         dmag_c;
	logic signed [COF_W-1:0]  cof_c [9];
	logic [COF_W-1:0]         cmag_c [9];
	logic [XW-1:0]            ld_rem [9];
	logic                     ld_neg [9];

	logic [XW-1:0]            dsh_c [1:NS-1];
	logic                     ge_c [1:NS-1][9];
	logic [XW-1:0]            rem_n [1:NS-1][9];
	logic [DATA_W-1:0]        quo_n [1:NS-1][9];
	logic                     big_n [1:NS-1][9];

	logic [DATA_W-1:0]        lim_c [9];
	logic [DATA_W-1:0]        qv_c [9];
	logic [DATA_W-1:0]        res_c [9];

	assign en = !v_s[NS-1] || !oq_full;
	assign mq_pop = en && !mq_empty;
	assign oq_push = en && v_s[NS-1];

	// take signs off the determinant and the cofactors
	always_comb begin
		det_c = $signed(mq_item.det);
		dneg_c = det_c[DET_W-1];
		dmag_c = dneg_c ? DET_W'(-det_c) : DET_W'(det_c);
		for (int k = 0; k < 9; k++) begin
			cof_c[k] = $signed(mq_item.cof[k]);
			cmag_c[k] = cof_c[k][COF_W-1] ? COF_W'(-cof_c[k]) : COF_W'(cof_c[k]);
			ld_rem[k] = XW'({cmag_c[k][2*DATA_W-1:0], {(2*FRAC_BITS){1'b0}}});
			ld_neg[k] = cof_c[k][COF_W-1] ^ dneg_c;
		end
	end

	// overflow check, then one restoring step per quotient bit
	always_comb begin
		for (int st = 1; st < NS; st++) begin
			if (st == 1) begin
				dsh_c[st] = dmag_s[st-1] << DATA_W;
			end else begin
				dsh_c[st] = dmag_s[st-1] << (DATA_W + 1 - st);
			end
			for (int k = 0; k < 9; k++) begin
				ge_c[st][k] = (rem_s[st-1][k] >= dsh_c[st]);
				if (st == 1) begin
					rem_n[st][k] = rem_s[st-1][k];
					quo_n[st][k] = '0;
					big_n[st][k] = ge_c[st][k];
				end else begin
					rem_n[st][k] = ge_c[st][k] ? rem_s[st-1][k] - dsh_c[st]
						: rem_s[st-1][k];
					quo_n[st][k] = quo_s[st-1][k];
					quo_n[st][k][DATA_W+1-st] = ge_c[st][k];
					big_n[st][k] = big_s[st-1][k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int st = 0; st < NS; st++) begin
				v_s[st] <= 1'b0;
			end
		end else if (en) begin
			v_s[0] <= mq_pop;
			for (int st = 1; st < NS; st++) begin
				v_s[st] <= v_s[st-1];
			end
		end
	end

	// advance the quotient pipe
	always_ff @(posedge clk) begin
		if (en) begin
			dmag_s[0] <= XW'(dmag_c);
			sing_s[0] <= mq_item.sing;
			for (int k = 0; k < 9; k++) begin
				rem_s[0][k] <= ld_rem[k];
				neg_s[0][k] <= ld_neg[k];
			end
			for (int st = 1; st < NS; st++) begin
				dmag_s[st] <= dmag_s[st-1];
				sing_s[st] <= sing_s[st-1];
				for (int k = 0; k < 9; k++) begin
					rem_s[st][k] <= rem_n[st][k];
					quo_s[st][k] <= quo_n[st][k];
					big_s[st][k] <= big_n[st][k];
					neg_s[st][k] <= neg_s[st-1][k];
				end
			end
		end
	end

	// saturate, restore the sign, zero a singular result
	always_comb begin
		for (int k = 0; k < 9; k++) begin
			lim_c[k] = neg_s[NS-1][k] ? {1'b1, {(DATA_W-1){1'b0}}}
				: {1'b0, {(DATA_W-1){1'b1}}};
			qv_c[k] = (big_s[NS-1][k] || quo_s[NS-1][k] > lim_c[k]) ? lim_c[k]
				: quo_s[NS-1][k];
			if (sing_s[NS-1]) begin
				res_c[k] = '0;
			end else begin
				res_c[k] = neg_s[NS-1][k] ? -qv_c[k] : qv_c[k];
			end
		end
		oq_data.inv00 = res_c[0];
		oq_data.inv01 = res_c[1];
		oq_data.inv02 = res_c[2];
		oq_data.inv10 = res_c[3];
		oq_data.inv11 = res_c[4];
		oq_data.inv12 = res_c[5];
		oq_data.inv20 = res_c[6];
		oq_data.inv21 = res_c[7];
		oq_data.inv22 = res_c[8];
		oq_data.singular = sing_s[NS-1];
	end

endmodule

[rtl/matrix_inverse_3x3.sv]
// channel   direction  handshake           payload
// matrix    in         push / full         mat (nine Q16.16 elements, row by row)
// inverse   out        pop / empty         inv (nine Q16.16 elements, singular)
//
// Sustains one matrix per cycle unless a full queue stalls it. Each matrix
// passes the cofactor and determinant stages, the middle queue, the back
// pipe, where the divider takes one quotient bit per stage, and the result
// queue.
// Reset clears every valid bit and queue count; payload registers keep junk.
// A stalled result output holds the back pipe; a full middle queue holds the
// front pipe and raises full. The middle queue decouples the two until full.
module matrix_inverse_3x3 #(
	parameter int FRAC_BITS = minv3_pkg::FRAC_BITS_DEF,
	parameter int MQ_DEPTH = minv3_pkg::MQ_DEPTH_DEF,
	parameter int OQ_DEPTH = minv3_pkg::OQ_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  minv3_pkg::mat_t  mat,
	output logic             empty,
	input  logic             pop,
	output minv3_pkg::inv_t  inv
);

	import minv3_pkg::*;

	logic  mq_push, mq_full, mq_pop, mq_empty;
	item_t mq_wdata, mq_rdata;
	logic  oq_push, oq_full;
	inv_t  oq_wdata;

	minv3_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.mat     (mat),
		.mq_push (mq_push),
		.mq_full (mq_full),
		.mq_item (mq_wdata)
	);

	minv3_fifo #(
		.WIDTH ($bits(item_t)),
		.DEPTH (MQ_DEPTH)
	) u_midq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mq_push),
		.full   (mq_full),
		.wdata  (mq_wdata),
		.pop    (mq_pop),
		.empty  (mq_empty),
		.rdata  (mq_rdata)
	);

	minv3_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.mq_empty (mq_empty),
		.mq_item  (mq_rdata),
		.mq_pop   (mq_pop),
		.oq_full  (oq_full),
		.oq_push  (oq_push),
		.oq_data  (oq_wdata)
	);

	minv3_fifo #(
		.WIDTH ($bits(inv_t)),
		.DEPTH (OQ_DEPTH)
	) u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (oq_push),
		.full   (oq_full),
		.wdata  (oq_wdata),
		.pop    (pop),
		.empty  (empty),
		.rdata  (inv)
	);

	// a singular result carries all-zero elements
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && inv.singular) |-> (inv.inv00 == '0 && inv.inv01 == '0 &&
		inv.inv02 == '0 && inv.inv10 == '0 && inv.inv11 == '0 &&
		inv.inv12 == '0 && inv.inv20 == '0 && inv.inv21 == '0 && inv.inv22 == '0))
		else $error("singular result with nonzero elements");

	// the front only backs up when the middle queue is full
	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> mq_full)
		else $error("full raised with room in the middle queue");

	// the back pipe never drops a beat into a full result queue
	a_oq_room: assert property (@(posedge clk) disable iff (!arst_n)
		oq_push |-> !oq_full)
		else $error("result beat pushed into a full queue");

endmodule
